// ----- design/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LWDH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lwdh assertion failed");

// next-cycle implication
`define LWDH_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lwdh assertion failed");

`endif

// ----- design/lwdh_pkg.sv -----
// types and constants of the luma weighted downsample and blur block
`default_nettype none
package lwdh_pkg;

   typedef struct packed {
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
   } rgb_type;

   typedef struct packed {
      logic [13:0] r;
      logic [13:0] g;
      logic [13:0] b;
   } quarter_type;

   typedef struct packed {
      logic [14:0] r;
      logic [14:0] g;
      logic [14:0] b;
   } pair_type;

   typedef struct packed {
      logic [23:0] r;
      logic [23:0] g;
      logic [23:0] b;
   } psum_type;

   typedef struct packed {
      logic has_main;
      logic blur;
      logic tail;
   } emit_type;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;
   localparam logic [CSR_DATA_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

   localparam int unsigned MIN_HALF_WIDTH = 7;
   localparam int unsigned EDGE_COLS      = 6;
   localparam int unsigned TAPS           = 13;

   localparam logic [15:0] LUM_R = 16'd23763;
   localparam logic [15:0] LUM_G = 16'd33764;
   localparam logic [15:0] LUM_B = 16'd8008;

   // ceil(2^32 / 246), exact for sums below 2^24
   localparam logic [24:0] BLUR_RECIP = 25'd17459217;

   localparam logic [6:0] BLUR_WEIGHT [TAPS] =
      '{7'd3, 7'd4, 7'd6, 7'd10, 7'd20, 7'd40, 7'd80, 7'd40, 7'd20, 7'd10, 7'd6, 7'd4, 7'd3};

endpackage
`default_nettype wire

// ----- design/lwdh_cell.sv -----
// one blur cell: window sample plus transposed partial sum
`default_nettype none
module lwdh_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire logic [6:0]        tap_weight,
   input  wire lwdh_pkg::rgb_type new_pix,
   input  wire lwdh_pkg::rgb_type nxt_pix,
   input  wire lwdh_pkg::psum_type nxt_psum,
   output lwdh_pkg::rgb_type      pix,
   output lwdh_pkg::psum_type     psum
);

   lwdh_pkg::rgb_type  pix_ff;
   lwdh_pkg::psum_type psum_ff;
   lwdh_pkg::psum_type psum_in;

   always_comb begin
      psum_in.r = nxt_psum.r + 24'(tap_weight) * 24'(new_pix.r);
      psum_in.g = nxt_psum.g + 24'(tap_weight) * 24'(new_pix.g);
      psum_in.b = nxt_psum.b + 24'(tap_weight) * 24'(new_pix.b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff  <= '0;
         psum_ff <= '0;
      end else if (shift_en) begin
         pix_ff  <= nxt_pix;
         psum_ff <= psum_in;
      end
   end

   assign pix  = pix_ff;
   assign psum = psum_ff;

endmodule
`default_nettype wire

// ----- design/lwdh_front.sv -----
// input side: counters, line store, box sum and luma scaling stages
`default_nettype none
module lwdh_front #(
   parameter int unsigned MAX_HALF_WIDTH  = 1024,
   parameter int unsigned MAX_HALF_HEIGHT = 1024,
   localparam int unsigned COL_W = $clog2(2 * MAX_HALF_WIDTH),
   localparam int unsigned CW    = COL_W - 1,
   localparam int unsigned ROW_W = $clog2(2 * MAX_HALF_HEIGHT)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [lwdh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lwdh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [15:0]                      req_in_red,
   input  wire logic [15:0]                      req_in_green,
   input  wire logic [15:0]                      req_in_blue,
   input  wire logic                             adv,
   output logic                                  sc_valid,
   output lwdh_pkg::rgb_type                     sc_pix,
   output lwdh_pkg::emit_type                    sc_emit,
   output logic [CW-1:0]                         sc_col,
   output logic [ROW_W-1:0]                      sc_row
);

   logic [lwdh_pkg::CSR_DATA_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   lwdh_pkg::quarter_type left_ff, q;
   lwdh_pkg::pair_type    line_mem [MAX_HALF_WIDTH];
   lwdh_pkg::pair_type    line_rd_ff;
   int unsigned hw, hh;
   logic [CW-1:0] c;
   logic accept;
   lwdh_pkg::emit_type emit_in;

   logic v1_ff, v1_in, v2_ff, v3_ff, v4_ff;
   lwdh_pkg::quarter_type q1_ff, left1_ff;
   lwdh_pkg::emit_type emit1_ff, emit2_ff, emit3_ff, emit4_ff;
   logic [CW-1:0] c1_ff, c2_ff, c3_ff, c4_ff;
   logic [ROW_W-1:0] row1_ff, row2_ff, row3_ff, row4_ff;
   lwdh_pkg::rgb_type box2_in, box2_ff, box3_ff, sc4_ff;
   logic [31:0] pr2_ff, pg2_ff, pb2_ff, lum_sum;
   logic [15:0] lum3_ff;
   logic [31:0] scr, scg, scb;

   always_comb begin
      hw = 32'(width_ff[lwdh_pkg::CSR_DATA_W-1:1]);
      if (hw < lwdh_pkg::MIN_HALF_WIDTH) hw = lwdh_pkg::MIN_HALF_WIDTH;
      if (hw > MAX_HALF_WIDTH) hw = MAX_HALF_WIDTH;
      hh = 32'(height_ff[lwdh_pkg::CSR_DATA_W-1:1]);
      if (hh < 1) hh = 1;
      if (hh > MAX_HALF_HEIGHT) hh = MAX_HALF_HEIGHT;
   end

   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign c         = col_ff[COL_W-1:1];
   assign q.r       = req_in_red[15:2];
   assign q.g       = req_in_green[15:2];
   assign q.b       = req_in_blue[15:2];

   always_comb begin
      if (32'(col_ff) + 32'd1 >= 2 * hw) begin
         col_in = '0;
         if (32'(row_ff) + 32'd1 >= 2 * hh) row_in = '0;
         else row_in = ROW_W'(32'(row_ff) + 32'd1);
      end else begin
         col_in = COL_W'(32'(col_ff) + 32'd1);
         row_in = row_ff;
      end
      emit_in.has_main = 32'(c) >= lwdh_pkg::EDGE_COLS;
      emit_in.blur     = 32'(c) >= 2 * lwdh_pkg::EDGE_COLS;
      emit_in.tail     = 32'(c) + 32'd1 >= hw;
      v1_in            = accept && col_ff[0] && row_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lwdh_pkg::IMAGE_WIDTH_RESET;
         height_ff <= lwdh_pkg::IMAGE_HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               lwdh_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               lwdh_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end else if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept && !col_ff[0]) left_ff <= q;
         if (adv) begin
            v1_ff <= v1_in;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
      end
   end

   // line store of horizontal pair sums from the even row
   always_ff @(posedge clock) begin
      if (accept && col_ff[0] && !row_ff[0]) begin
         line_mem[c] <= '{r: 15'(left_ff.r) + 15'(q.r),
                          g: 15'(left_ff.g) + 15'(q.g),
                          b: 15'(left_ff.b) + 15'(q.b)};
      end
      if (accept) line_rd_ff <= line_mem[c];
   end

   always_comb begin
      box2_in.r = 16'(line_rd_ff.r) + 16'(left1_ff.r) + 16'(q1_ff.r);
      box2_in.g = 16'(line_rd_ff.g) + 16'(left1_ff.g) + 16'(q1_ff.g);
      box2_in.b = 16'(line_rd_ff.b) + 16'(left1_ff.b) + 16'(q1_ff.b);
      lum_sum   = pr2_ff + pg2_ff + pb2_ff;
      scr       = 32'(box3_ff.r) * 32'(lum3_ff);
      scg       = 32'(box3_ff.g) * 32'(lum3_ff);
      scb       = 32'(box3_ff.b) * 32'(lum3_ff);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q1_ff    <= q;
         left1_ff <= left_ff;
         c1_ff    <= c;
         row1_ff  <= row_ff;
         emit1_ff <= emit_in;
      end
      if (adv) begin
         box2_ff  <= box2_in;
         pr2_ff   <= 32'(box2_in.r) * 32'(lwdh_pkg::LUM_R);
         pg2_ff   <= 32'(box2_in.g) * 32'(lwdh_pkg::LUM_G);
         pb2_ff   <= 32'(box2_in.b) * 32'(lwdh_pkg::LUM_B);
         c2_ff    <= c1_ff;
         row2_ff  <= row1_ff;
         emit2_ff <= emit1_ff;
         box3_ff  <= box2_ff;
         lum3_ff  <= lum_sum[31:16];
         c3_ff    <= c2_ff;
         row3_ff  <= row2_ff;
         emit3_ff <= emit2_ff;
         sc4_ff   <= '{r: scr[31:16], g: scg[31:16], b: scb[31:16]};
         c4_ff    <= c3_ff;
         row4_ff  <= row3_ff;
         emit4_ff <= emit3_ff;
      end
   end

   assign sc_valid = v4_ff;
   assign sc_pix   = sc4_ff;
   assign sc_emit  = emit4_ff;
   assign sc_col   = c4_ff;
   assign sc_row   = row4_ff;

endmodule
`default_nettype wire

// ----- design/luma_weighted_downsample_hblur_top.sv -----
// Throughput: one pixel per cycle; the seven results of a row end drain while the
// next even row streams in, so the input stalls only under result back-pressure.
// Blur runs in a 13-cell chain of transposed partial sums, one shift per half pixel.
// Reset: synchronous, active high; clears counters, window cells and valid flags and reloads the size registers.
`default_nettype none
module luma_weighted_downsample_hblur_top #(
   parameter int unsigned MAX_HALF_WIDTH  = 1024,
   parameter int unsigned MAX_HALF_HEIGHT = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [lwdh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lwdh_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [15:0]                      req_in_red,
   input  wire logic [15:0]                      req_in_green,
   input  wire logic [15:0]                      req_in_blue,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [15:0]                           rsp_out_red,
   output logic [15:0]                           rsp_out_green,
   output logic [15:0]                           rsp_out_blue,
   output logic [9:0]                            rsp_out_column,
   output logic [9:0]                            rsp_out_row,
   output logic                                  rsp_run_last
);

   localparam int unsigned CW    = $clog2(2 * MAX_HALF_WIDTH) - 1;
   localparam int unsigned ROW_W = $clog2(2 * MAX_HALF_HEIGHT);

   logic adv;
   logic sc_valid;
   lwdh_pkg::rgb_type  sc_pix;
   lwdh_pkg::emit_type sc_emit;
   logic [CW-1:0]    sc_col;
   logic [ROW_W-1:0] sc_row;

   lwdh_front #(
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
      .MAX_HALF_HEIGHT(MAX_HALF_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_red  (req_in_red),
      .req_in_green(req_in_green),
      .req_in_blue (req_in_blue),
      .adv         (adv),
      .sc_valid    (sc_valid),
      .sc_pix      (sc_pix),
      .sc_emit     (sc_emit),
      .sc_col      (sc_col),
      .sc_row      (sc_row)
   );

   // cell chain, newest sample enters at the right
   lwdh_pkg::rgb_type  samp [lwdh_pkg::TAPS+1];
   lwdh_pkg::psum_type psum [lwdh_pkg::TAPS+1];
   logic shift_en;

   assign shift_en                 = adv && sc_valid;
   assign samp[lwdh_pkg::TAPS]     = sc_pix;
   assign psum[lwdh_pkg::TAPS]     = '0;

   for (genvar j = 0; j < lwdh_pkg::TAPS; j++) begin : g_cell
      lwdh_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .tap_weight(lwdh_pkg::BLUR_WEIGHT[j]),
         .new_pix   (sc_pix),
         .nxt_pix   (samp[j+1]),
         .nxt_psum  (psum[j+1]),
         .pix       (samp[j]),
         .psum      (psum[j])
      );
   end

   // stage after the chain push
   logic v5_ff;
   lwdh_pkg::emit_type emit5_ff;
   logic [CW-1:0]    c5_ff;
   logic [ROW_W-1:0] row5_ff;

   // result bank of one half column and its tail
   logic bank_valid_ff;
   logic [2:0] bank_idx_ff;
   logic bank_tail_ff, bank_blur_ff;
   lwdh_pkg::rgb_type bank_quo_ff;
   lwdh_pkg::rgb_type bank_s_ff [lwdh_pkg::EDGE_COLS+1];
   logic [CW-1:0] bank_col_ff;
   logic [9:0]    bank_row_ff;
   logic [63:0]   quo_r, quo_g, quo_b;
   logic out_load, bank_emit, bank_last, bank_free, bank_load;
   lwdh_pkg::rgb_type out_pix;
   logic [31:0] row32;

   assign out_load  = !rsp_valid || rsp_ready;
   assign bank_emit = bank_valid_ff && out_load;
   assign bank_last = bank_tail_ff ? (bank_idx_ff == 3'(lwdh_pkg::EDGE_COLS))
                                   : (bank_idx_ff == 3'd0);
   assign bank_free = !bank_valid_ff || (bank_emit && bank_last);
   assign adv       = !v5_ff || bank_free;
   assign bank_load = adv && v5_ff;

   always_comb begin
      quo_r   = 64'(psum[0].r) * 64'(lwdh_pkg::BLUR_RECIP);
      quo_g   = 64'(psum[0].g) * 64'(lwdh_pkg::BLUR_RECIP);
      quo_b   = 64'(psum[0].b) * 64'(lwdh_pkg::BLUR_RECIP);
      row32   = 32'(row5_ff) >> 1;
      if (bank_idx_ff == 3'd0 && bank_blur_ff) out_pix = bank_quo_ff;
      else out_pix = bank_s_ff[bank_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff         <= 1'b0;
         bank_valid_ff <= 1'b0;
         bank_idx_ff   <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         if (adv) v5_ff <= sc_valid && sc_emit.has_main;
         if (bank_load) begin
            bank_valid_ff <= 1'b1;
            bank_idx_ff   <= '0;
         end else if (bank_emit) begin
            bank_idx_ff <= bank_idx_ff + 3'd1;
            if (bank_last) bank_valid_ff <= 1'b0;
         end
         if (out_load) rsp_valid <= bank_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         emit5_ff <= sc_emit;
         c5_ff    <= sc_col;
         row5_ff  <= sc_row;
      end
      if (bank_load) begin
         bank_tail_ff <= emit5_ff.tail;
         bank_blur_ff <= emit5_ff.blur;
         bank_quo_ff  <= '{r: quo_r[47:32], g: quo_g[47:32], b: quo_b[47:32]};
         for (int k = 0; k <= lwdh_pkg::EDGE_COLS; k++) begin
            bank_s_ff[k] <= samp[lwdh_pkg::EDGE_COLS + k];
         end
         bank_col_ff  <= CW'(32'(c5_ff) - lwdh_pkg::EDGE_COLS);
         bank_row_ff  <= row32[9:0];
      end
      if (bank_emit) begin
         rsp_out_red    <= out_pix.r;
         rsp_out_green  <= out_pix.g;
         rsp_out_blue   <= out_pix.b;
         rsp_out_column <= 10'(32'(bank_col_ff) + 32'(bank_idx_ff));
         rsp_out_row    <= bank_row_ff;
         rsp_run_last   <= bank_last;
      end
   end

endmodule
`default_nettype wire

// ----- design/lwdh_checker.sv -----
// port-level checker bound to the top level
`default_nettype none
`include "assert_macros.svh"
module lwdh_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [15:0] rsp_out_red,
   input wire logic [15:0] rsp_out_green,
   input wire logic [15:0] rsp_out_blue,
   input wire logic [9:0] rsp_out_column,
   input wire logic [9:0] rsp_out_row,
   input wire logic       rsp_run_last
);

   // stalled transaction holds
   `LWDH_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_out_column) && $stable(rsp_out_row) && $stable(rsp_run_last))

   // input held off only while results are draining
   `LWDH_ASSERT_NXT(a_stall_drains, clock, reset, !req_ready, rsp_valid)

   // a run continues without a gap along the same row
   `LWDH_ASSERT_NXT(a_run_cont, clock, reset, rsp_valid && rsp_ready && !rsp_run_last, rsp_valid && rsp_out_row == $past(rsp_out_row) && rsp_out_column == 10'($past(rsp_out_column) + 10'd1))

endmodule

bind luma_weighted_downsample_hblur_top lwdh_checker u_lwdh_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_out_column(rsp_out_column),
   .rsp_out_row   (rsp_out_row),
   .rsp_run_last  (rsp_run_last)
);
`default_nettype wire

// ----- dv/tb.sv -----
// testbench of the luma weighted downsample and blur block, self-checking
`default_nettype none
module tb;

   typedef struct {
      lwdh_pkg::rgb_type pix;
      logic [9:0]  col;
      logic [9:0]  row;
      logic        last;
   } half_pixel_type;

   class luma_blur_scoreboard;
      logic [14:0]  pair_line [1024][3];
      logic [13:0]  left_q [3];
      logic [15:0]  window [13][3];
      int unsigned  col_pos, row_pos;
      logic [11:0]  width_reg, height_reg;
      half_pixel_type expected_pixels [$];
      int unsigned  mismatches, checked, pixels_in;

      function new();
         foreach (pair_line[i, c]) pair_line[i][c] = '0;
         foreach (window[i, c]) window[i][c] = '0;
         foreach (left_q[c]) left_q[c] = '0;
         col_pos = 0; row_pos = 0;
         width_reg = lwdh_pkg::IMAGE_WIDTH_RESET;
         height_reg = lwdh_pkg::IMAGE_HEIGHT_RESET;
      endfunction

      function int unsigned half_w();
         int unsigned h;
         h = 32'(width_reg[11:1]);
         if (h < 7) h = 7;
         if (h > 1024) h = 1024;
         return h;
      endfunction

      function int unsigned half_h();
         int unsigned h;
         h = 32'(height_reg[11:1]);
         if (h < 1) h = 1;
         if (h > 1024) h = 1024;
         return h;
      endfunction

      function void write_reg(logic [lwdh_pkg::CSR_IDX_W-1:0] idx,
                              logic [lwdh_pkg::CSR_DATA_W-1:0] val);
         if (idx == lwdh_pkg::CSR_IMAGE_WIDTH) width_reg = val;
         else height_reg = val;
         col_pos = 0; row_pos = 0;
      endfunction

      function void push_pixel(logic [15:0] p [3], int unsigned x, int unsigned y);
         half_pixel_type e;
         e.pix.r = p[0]; e.pix.g = p[1]; e.pix.b = p[2];
         e.col = x[9:0]; e.row = y[9:0]; e.last = 1'b0;
         expected_pixels.push_back(e);
      endfunction

      function void note_pixel(lwdh_pkg::rgb_type px);
         int unsigned  hw, hh, c, yrow, n0, x;
         logic [13:0]  q [3];
         int unsigned  box [3];
         longint unsigned lum, acc;
         logic [15:0]  tmp [3];
         pixels_in++;
         hw = half_w(); hh = half_h();
         c = col_pos >> 1; yrow = row_pos >> 1;
         if (c > 1023) c = 1023;
         q[0] = px.r[15:2]; q[1] = px.g[15:2]; q[2] = px.b[15:2];
         n0 = expected_pixels.size();
         if (!col_pos[0]) begin
            left_q = q;
         end else if (!row_pos[0]) begin
            for (int ch = 0; ch < 3; ch++)
               pair_line[c][ch] = 15'(left_q[ch]) + 15'(q[ch]);
         end else begin
            for (int ch = 0; ch < 3; ch++)
               box[ch] = 32'(pair_line[c][ch]) + 32'(left_q[ch]) + 32'(q[ch]);
            lum = (64'd23763 * box[0] + 64'd33764 * box[1] + 64'd8008 * box[2]) >> 16;
            for (int t = 0; t < 12; t++) window[t] = window[t+1];
            for (int ch = 0; ch < 3; ch++)
               window[12][ch] = 16'((64'(box[ch]) * lum) >> 16);
            if (c >= 6) begin
               x = c - 6;
               if (x >= 6) begin
                  for (int ch = 0; ch < 3; ch++) begin
                     acc = 0;
                     for (int t = 0; t < 13; t++)
                        acc += 64'(lwdh_pkg::BLUR_WEIGHT[t]) * 64'(window[t][ch]);
                     tmp[ch] = 16'(acc / 246);
                  end
                  push_pixel(tmp, x, yrow);
               end else push_pixel(window[6], x, yrow);
            end
            if (c + 1 >= hw)
               for (x = c - 5; x <= c; x++) push_pixel(window[12 - (c - x)], x, yrow);
            if (expected_pixels.size() > n0)
               expected_pixels[expected_pixels.size()-1].last = 1'b1;
         end
         if (col_pos + 1 >= 2 * hw) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= 2 * hh) ? 0 : row_pos + 1;
         end else col_pos++;
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         $display("mismatch on %s: got %0d expected %0d", what, got, want);
         mismatches++;
      endtask

      task check_result(half_pixel_type r);
         half_pixel_type e;
         checked++;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected transaction, column", 32'(r.col), 0);
            return;
         end
         e = expected_pixels.pop_front();
         if (r.pix.r !== e.pix.r) report_mismatch("red", 32'(r.pix.r), 32'(e.pix.r));
         if (r.pix.g !== e.pix.g) report_mismatch("green", 32'(r.pix.g), 32'(e.pix.g));
         if (r.pix.b !== e.pix.b) report_mismatch("blue", 32'(r.pix.b), 32'(e.pix.b));
         if (r.col !== e.col) report_mismatch("column", 32'(r.col), 32'(e.col));
         if (r.row !== e.row) report_mismatch("row", 32'(r.row), 32'(e.row));
         if (r.last !== e.last) report_mismatch("run_last", 32'(r.last), 32'(e.last));
      endtask
   endclass

   logic clock = 1'b0, reset = 1'b1;
   logic csr_we = 1'b0;
   logic [lwdh_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [lwdh_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0, req_ready;
   logic [15:0] req_in_red = '0, req_in_green = '0, req_in_blue = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [15:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic [9:0] rsp_out_column, rsp_out_row;
   logic rsp_run_last;
   bit no_idle = 1'b0;
   int unsigned phases = 0;
   luma_blur_scoreboard sb = new();

   luma_weighted_downsample_hblur_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      int unsigned n;
      n = gap_len();
      if (n == 0) rsp_ready = 1'b1;
      else begin
         rsp_ready = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      half_pixel_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         r.pix = {rsp_out_red, rsp_out_green, rsp_out_blue};
         r.col = rsp_out_column; r.row = rsp_out_row; r.last = rsp_run_last;
         sb.check_result(r);
      end
   end

   task automatic write_csr(logic [lwdh_pkg::CSR_IDX_W-1:0] idx,
                            logic [lwdh_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1; csr_index = idx; csr_wdata = val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_pixel(lwdh_pkg::rgb_type px);
      int unsigned n;
      n = gap_len();
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      {req_in_red, req_in_green, req_in_blue} = px;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(px);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(logic [11:0] w, logic [11:0] h, int unsigned count);
      lwdh_pkg::rgb_type px;
      write_csr(lwdh_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(lwdh_pkg::CSR_IMAGE_HEIGHT, h);
      @(negedge clock);
      phases++;
      for (int i = 0; i < count; i++) begin
         px = {rand_sample(), rand_sample(), rand_sample()};
         send_pixel(px);
      end
      drain();
   endtask

   initial begin
      int unsigned hw, hh, sent;
      logic [11:0] w, h;
      lwdh_pkg::rgb_type px;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: narrowest row, saturated and zero pixels
      write_csr(lwdh_pkg::CSR_IMAGE_WIDTH, 12'd14);
      write_csr(lwdh_pkg::CSR_IMAGE_HEIGHT, 12'd2);
      for (int i = 0; i < 28; i++) begin
         case (i % 4)
            0: px = {16'hffff, 16'hffff, 16'hffff};
            1: px = {16'hffff, 16'h0000, 16'h0003};
            2: px = {16'h0000, 16'hffff, 16'h8000};
            default: px = {16'h0001, 16'h0002, 16'hfffc};
         endcase
         send_pixel(px);
      end
      drain();
      phases++;

      sent = 0;
      while (sent < 280) begin
         no_idle = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: w = 12'd0;
            1: w = 12'd15;
            2: w = 12'd13;
            default: w = 12'($urandom_range(14, 64));
         endcase
         case ($urandom_range(0, 4))
            0: h = 12'd0;
            1: h = 12'd3;
            default: h = 12'(2 * $urandom_range(1, 3));
         endcase
         hw = 32'(w[11:1]); if (hw < 7) hw = 7;
         hh = 32'(h[11:1]); if (hh < 1) hh = 1;
         hw = 4 * hw * hh;
         if ($urandom_range(0, 3) == 0) hw = $urandom_range(1, hw);
         if (hw > 280 - sent) hw = 280 - sent;
         run_phase(w, h, hw);
         sent += hw;
      end

      // widest row and tallest frame left unfinished, then a narrow tall frame
      no_idle = 1'b0;
      run_phase(12'd4095, 12'd2, 40);
      run_phase(12'd2048, 12'd4095, 28);
      run_phase(12'd14, 12'd2048, 56);

      $display("covered %0d pixel transactions over %0d frame settings", sb.pixels_in, phases);
      $display("%0d result transactions checked", sb.checked);
      if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(12 * 3000000);
      $display("timeout waiting for the block");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
